// ===== design/flash_erase_range_planner_assert.svh =====
// ----------------------------------------------------------------------------
// flash_erase_range_planner_assert.svh
// Assertion macros for the erase range planner. Each macro samples on the
// rising edge of clk and is disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef FLASH_ERASE_RANGE_PLANNER_ASSERT_SVH
`define FLASH_ERASE_RANGE_PLANNER_ASSERT_SVH

// Same-cycle implication.
`define FER_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("erase planner: same-cycle check failed");

// Next-cycle implication.
`define FER_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("erase planner: next-cycle check failed");

`endif

// ===== design/fer_pkg.sv =====
// ----------------------------------------------------------------------------
// fer_pkg
// Types and constants shared by the erase range planner modules.
// ----------------------------------------------------------------------------
package fer_pkg;

    localparam int OFS_W      = 24;
    localparam int LEN_W      = 25;
    localparam int OUT_ADDR_W = 24;
    localparam int OPC_W      = 8;

    localparam int SECTOR_BYTES = 4096;
    localparam int SECTOR_SHIFT = 12;

    localparam logic [LEN_W-1:0] SECTOR_LEN = LEN_W'(SECTOR_BYTES);
    localparam logic [LEN_W-1:0] BLK32_LEN  = 25'h0_8000;
    localparam logic [LEN_W-1:0] BLK64_LEN  = 25'h1_0000;

    localparam logic [OPC_W-1:0] OPC_NONE   = 8'h00;
    localparam logic [OPC_W-1:0] OPC_SECTOR = 8'h20;
    localparam logic [OPC_W-1:0] OPC_BLK32  = 8'h52;
    localparam logic [OPC_W-1:0] OPC_BLK64  = 8'hD8;

    typedef enum logic [2:0] {
        ST_ISSUE   = 3'd0,
        ST_DONE    = 3'd1,
        ST_REJECT  = 3'd2,
        ST_ABORT   = 3'd3,
        ST_IGNORED = 3'd4
    } fer_status_t;

    typedef enum logic {
        OP_START    = 1'b0,
        OP_COMPLETE = 1'b1
    } fer_op_t;

    typedef struct packed {
        fer_op_t          op;
        logic [OFS_W-1:0] start_offset;
        logic [LEN_W-1:0] region_length;
        logic             cmd_failed;
    } fer_item_t;

    typedef struct packed {
        fer_status_t           status;
        logic [OPC_W-1:0]      erase_opcode;
        logic [OUT_ADDR_W-1:0] erase_address;
    } fer_result_t;

endpackage

// ===== design/fer_step.sv =====
// ----------------------------------------------------------------------------
// fer_step
// Decision logic for one event: checks a start request, picks the next erase
// command greedily and computes the updated request state.
// ----------------------------------------------------------------------------
module fer_step #(
    parameter int ADDR_BITS = 24
) (
    input  fer_pkg::fer_item_t        item,
    input  logic                      cur_busy,
    input  logic [ADDR_BITS-1:0]      cur_address,
    input  logic [fer_pkg::LEN_W-1:0] cur_left,
    output logic                      new_busy,
    output logic [ADDR_BITS-1:0]      new_address,
    output logic [fer_pkg::LEN_W-1:0] new_left,
    output fer_pkg::fer_result_t      result
);
    import fer_pkg::*;

    localparam int SUM_W = (ADDR_BITS + 1 > LEN_W + 1) ? ADDR_BITS + 1 : LEN_W + 1;
    localparam logic [SUM_W-1:0] SPACE = SUM_W'(1) << ADDR_BITS;

    logic                 bad_req;
    logic [SUM_W-1:0]     range_end;
    logic                 from_start;
    logic [ADDR_BITS-1:0] src_addr;
    logic [LEN_W-1:0]     src_left;
    logic [LEN_W-1:0]     cmd_size;
    logic [OPC_W-1:0]     cmd_opc;

    assign range_end = SUM_W'(item.start_offset) + SUM_W'(item.region_length);
    assign bad_req   = (item.start_offset[SECTOR_SHIFT-1:0] != '0)
                    || (item.region_length < SECTOR_LEN)
                    || (item.region_length[SECTOR_SHIFT-1:0] != '0)
                    || (range_end > SPACE);

    assign from_start = (item.op == OP_START);
    assign src_addr   = from_start ? ADDR_BITS'(item.start_offset) : cur_address;
    assign src_left   = from_start ? item.region_length : cur_left;

    // Greedy pick: largest erase that is aligned and fits.
    always_comb
    begin
        if (src_addr[15:0] == '0 && src_left >= BLK64_LEN)
        begin
            cmd_size = BLK64_LEN;
            cmd_opc  = OPC_BLK64;
        end
        else if (src_addr[14:0] == '0 && src_left >= BLK32_LEN)
        begin
            cmd_size = BLK32_LEN;
            cmd_opc  = OPC_BLK32;
        end
        else if (src_left < SECTOR_LEN)
        begin
            cmd_size = src_left;
            cmd_opc  = OPC_SECTOR;
        end
        else
        begin
            cmd_size = SECTOR_LEN;
            cmd_opc  = OPC_SECTOR;
        end
    end

    always_comb
    begin
        new_busy    = cur_busy;
        new_address = cur_address;
        new_left    = cur_left;
        result      = '{status: ST_IGNORED, erase_opcode: OPC_NONE, erase_address: '0};
        if (from_start)
        begin
            if (cur_busy)
                result.status = ST_IGNORED;
            else if (bad_req)
                result.status = ST_REJECT;
            else
            begin
                new_busy      = 1'b1;
                new_address   = src_addr + ADDR_BITS'(cmd_size);
                new_left      = src_left - cmd_size;
                result.status = ST_ISSUE;
                result.erase_opcode  = cmd_opc;
                result.erase_address = OUT_ADDR_W'(src_addr);
            end
        end
        else if (!cur_busy)
            result.status = ST_IGNORED;
        else if (item.cmd_failed || cur_left == '0)
        begin
            new_busy      = 1'b0;
            new_address   = '0;
            new_left      = '0;
            result.status = item.cmd_failed ? ST_ABORT : ST_DONE;
        end
        else
        begin
            new_address   = src_addr + ADDR_BITS'(cmd_size);
            new_left      = src_left - cmd_size;
            result.status = ST_ISSUE;
            result.erase_opcode  = cmd_opc;
            result.erase_address = OUT_ADDR_W'(src_addr);
        end
    end

endmodule

// ===== design/flash_erase_range_planner.sv =====
// ----------------------------------------------------------------------------
// flash_erase_range_planner
// Splits a flash erase range into 64K, 32K and 4K erase commands.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one event per beat: op 0 is
//   a start request with start_offset and region_length, op 1 reports that
//   the last erase command completed, with cmd_failed set on error.
//   Output channel (out_valid / out_stall) returns exactly one result beat
//   per event: an erase command to issue (status 0 with opcode and address),
//   finished, rejected, aborted, or ignored (opcode and address are 0).
//   Each event passes the input register, then the result register; one event
//   is taken every cycle while out_stall is low. The single decision step
//   between the two registers also updates the request state.
//   While the receiver stalls, the result register holds and one more event
//   may wait in the input register; after that in_stall is raised.
//   Reset (rst_n low) empties both registers and leaves the block idle with
//   no request in progress.
// ----------------------------------------------------------------------------
`include "flash_erase_range_planner_assert.svh"

module flash_erase_range_planner #(
    parameter int ADDR_BITS = 24
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           op,
    input  logic [fer_pkg::OFS_W-1:0]      start_offset,
    input  logic [fer_pkg::LEN_W-1:0]      region_length,
    input  logic                           cmd_failed,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [2:0]                     status,
    output logic [fer_pkg::OPC_W-1:0]      erase_opcode,
    output logic [fer_pkg::OUT_ADDR_W-1:0] erase_address
);
    import fer_pkg::*;

    // Input register
    logic      in_full_reg, in_full_next;
    fer_item_t in_item_reg;

    // Request state
    logic                 busy_reg, busy_next;
    logic [ADDR_BITS-1:0] addr_reg, addr_next;
    logic [LEN_W-1:0]     left_reg, left_next;

    // Result register
    logic        out_full_reg, out_full_next;
    fer_result_t res_reg;
    fer_result_t res_next;

    logic advance;
    logic accept_in;

    // Advance the held event whenever the result slot is free or drains now.
    assign advance   = in_full_reg && (!out_full_reg || !out_stall);
    assign in_stall  = in_full_reg && !advance;
    assign accept_in = in_valid && !in_stall;

    assign in_full_next  = accept_in || (in_full_reg && !advance);
    assign out_full_next = advance || (out_full_reg && out_stall);

    fer_step #(
        .ADDR_BITS (ADDR_BITS)
    ) u_step (
        .item        (in_item_reg),
        .cur_busy    (busy_reg),
        .cur_address (addr_reg),
        .cur_left    (left_reg),
        .new_busy    (busy_next),
        .new_address (addr_next),
        .new_left    (left_next),
        .result      (res_next)
    );

    // Control and request state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg  <= 1'b0;
            out_full_reg <= 1'b0;
            busy_reg     <= 1'b0;
            addr_reg     <= '0;
            left_reg     <= '0;
        end
        else
        begin
            in_full_reg  <= in_full_next;
            out_full_reg <= out_full_next;
            if (advance)
            begin
                busy_reg <= busy_next;
                addr_reg <= addr_next;
                left_reg <= left_next;
            end
        end
    end

    // Payload registers: load on the matching handshake, hold otherwise.
    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            in_item_reg.op            <= fer_op_t'(op);
            in_item_reg.start_offset  <= start_offset;
            in_item_reg.region_length <= region_length;
            in_item_reg.cmd_failed    <= cmd_failed;
        end
        if (advance)
            res_reg <= res_next;
    end

    assign out_valid     = out_full_reg;
    assign status        = res_reg.status;
    assign erase_opcode  = res_reg.erase_opcode;
    assign erase_address = res_reg.erase_address;

    // Checks
    `FER_ASSERT_IMPL(a_no_cmd_unless_issue, out_valid && status != ST_ISSUE, erase_opcode == OPC_NONE && erase_address == '0)
    `FER_ASSERT_IMPL(a_idle_has_nothing_left, !busy_reg, left_reg == '0)
    `FER_ASSERT_IMPL(a_left_sector_multiple, busy_reg, left_reg[SECTOR_SHIFT-1:0] == '0)
    `FER_ASSERT_NEXT(a_end_goes_idle, advance && (res_next.status == ST_DONE || res_next.status == ST_ABORT), !busy_reg)
    `FER_ASSERT_IMPL(a_stall_only_when_full, in_stall, in_full_reg && out_full_reg && out_stall)

endmodule
